// File: rtl/line_follower_pid_drive_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the line follower drive core.
// ----------------------------------------------------------------------------
`ifndef LINE_FOLLOWER_PID_DRIVE_CORE_MACROS_SVH
`define LINE_FOLLOWER_PID_DRIVE_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define LFPD_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define LFPD_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/lfpd_pkg.sv
// ----------------------------------------------------------------------------
// lfpd_pkg
// Types and constants of the PID differential drive core.
// ----------------------------------------------------------------------------
package lfpd_pkg;

  localparam int GAIN_FRAC_BITS = 16;
  localparam int ACC_W          = 50;   // p + d + i products, signed

  typedef enum logic [2:0] {
    REG_LINE_TARGET   = 3'd0,
    REG_MAX_SPEED     = 3'd1,
    REG_GAIN_P        = 3'd2,
    REG_GAIN_I        = 3'd3,
    REG_GAIN_D        = 3'd4,
    REG_FINISH_EDGES  = 3'd5,
    REG_STOP_DELAY_MS = 3'd6
  } reg_idx_t;

  localparam logic [12:0] RST_LINE_TARGET   = 13'd3500;
  localparam logic [7:0]  RST_MAX_SPEED     = 8'd200;
  localparam logic [15:0] RST_GAIN_P        = 16'd6423;
  localparam logic [15:0] RST_GAIN_I        = 16'd0;
  localparam logic [15:0] RST_GAIN_D        = 16'd10486;
  localparam logic [3:0]  RST_FINISH_EDGES  = 4'd10;
  localparam logic [15:0] RST_STOP_DELAY_MS = 16'd500;

  localparam logic [4:0]  EDGE_MAX = 5'd31;

  typedef struct packed {
    logic [12:0] line_target;
    logic [7:0]  max_speed;
    logic [15:0] gain_p;
    logic [15:0] gain_i;
    logic [15:0] gain_d;
    logic [3:0]  finish_edges;
    logic [15:0] stop_delay_ms;
  } cfg_t;

  // Error stage to multiply stage.
  typedef struct packed {
    logic signed [13:0] err;
    logic signed [14:0] diff;
    logic signed [31:0] sum;
    logic               halted;
  } err_stage_t;

  // Multiply stage to drive stage.
  typedef struct packed {
    logic signed [30:0] prod_p;
    logic signed [31:0] prod_d;
    logic signed [48:0] prod_i;
    logic               halted;
  } mul_stage_t;

endpackage

// File: rtl/lfpd_if.sv
// ----------------------------------------------------------------------------
// lfpd_if
// Valid/ready channels of the drive core: control ticks in, drive levels out.
// ----------------------------------------------------------------------------
interface lfpd_tick_if;
  logic        valid;
  logic        ready;
  logic [12:0] line_position;
  logic        marker_level;
  logic [31:0] now_ms;

  modport source (output valid, line_position, marker_level, now_ms, input ready);
  modport sink   (input valid, line_position, marker_level, now_ms, output ready);
endinterface

interface lfpd_drive_if;
  logic       valid;
  logic       ready;
  logic [7:0] left_drive;
  logic [7:0] right_drive;
  logic       halted;

  modport source (output valid, left_drive, right_drive, halted, input ready);
  modport sink   (input valid, left_drive, right_drive, halted, output ready);
endinterface

// File: rtl/lfpd_err_stage.sv
// ----------------------------------------------------------------------------
// lfpd_err_stage
// Error, saturating sum, derivative term and finish-marker / stop tracking.
// ----------------------------------------------------------------------------
module lfpd_err_stage
  import lfpd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  cfg_t        cfg,
  input  logic [12:0] line_position,
  input  logic        marker_level,
  input  logic [31:0] now_ms,
  output err_stage_t  stage
);

  logic signed [13:0] previous_error;
  logic signed [31:0] error_sum;
  logic               marker_seen;
  logic [4:0]         edge_count;
  logic [31:0]        finish_time;
  logic               stopped;

  logic signed [13:0] err;
  logic signed [32:0] sum_wide;
  logic signed [31:0] sum_sat;
  logic signed [14:0] diff;
  logic [4:0]         count_bumped;
  logic               latch;
  logic [4:0]         edge_count_next;
  logic [31:0]        finish_time_next;
  logic [31:0]        elapsed;
  logic               stop_now;

  always_comb begin
    err      = $signed({1'b0, cfg.line_target}) - $signed({1'b0, line_position});
    sum_wide = {error_sum[31], error_sum} + {{19{err[13]}}, err};
    if (sum_wide[32] != sum_wide[31]) begin
      sum_sat = sum_wide[32] ? {1'b1, 31'b0} : {1'b0, {31{1'b1}}};
    end else begin
      sum_sat = sum_wide[31:0];
    end
    diff = {err[13], err} - {previous_error[13], previous_error};

    // count a rising marker edge, saturating
    if (marker_level && !marker_seen && (edge_count != EDGE_MAX)) begin
      count_bumped = edge_count + 5'd1;
    end else begin
      count_bumped = edge_count;
    end
    // arm the stop timer once the count reaches the target
    latch            = (count_bumped == {1'b0, cfg.finish_edges});
    edge_count_next  = latch ? count_bumped + 5'd1 : count_bumped;
    finish_time_next = latch ? now_ms : finish_time;
    elapsed          = now_ms - finish_time_next;
    stop_now         = (edge_count_next > {1'b0, cfg.finish_edges}) &&
                       (elapsed >= {16'b0, cfg.stop_delay_ms});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_error <= '0;
      error_sum      <= '0;
      marker_seen    <= 1'b0;
      edge_count     <= '0;
      finish_time    <= '0;
      stopped        <= 1'b0;
    end else if (load && !stopped) begin
      previous_error <= err;
      error_sum      <= sum_sat;
      marker_seen    <= marker_level;
      edge_count     <= edge_count_next;
      finish_time    <= finish_time_next;
      stopped        <= stop_now;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      stage.err    <= err;
      stage.diff   <= diff;
      stage.sum    <= sum_sat;
      stage.halted <= stopped || stop_now;
    end
  end

endmodule

// File: rtl/lfpd_mul_stage.sv
// ----------------------------------------------------------------------------
// lfpd_mul_stage
// Gain products of the proportional, derivative and integral terms.
// ----------------------------------------------------------------------------
module lfpd_mul_stage
  import lfpd_pkg::*;
(
  input  logic       clk,
  input  logic       load,
  input  cfg_t       cfg,
  input  err_stage_t src,
  output mul_stage_t stage
);

  logic signed [30:0] prod_p;
  logic signed [31:0] prod_d;
  logic signed [48:0] prod_i;

  always_comb begin
    prod_p = $signed({1'b0, cfg.gain_p}) * src.err;
    prod_d = $signed({1'b0, cfg.gain_d}) * src.diff;
    prod_i = $signed({1'b0, cfg.gain_i}) * src.sum;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      stage.prod_p <= prod_p;
      stage.prod_d <= prod_d;
      stage.prod_i <= prod_i;
      stage.halted <= src.halted;
    end
  end

endmodule

// File: rtl/lfpd_drv_stage.sv
// ----------------------------------------------------------------------------
// lfpd_drv_stage
// Correction sum, fractional shift and clamp of both motor drives.
// ----------------------------------------------------------------------------
module lfpd_drv_stage
  import lfpd_pkg::*;
(
  input  logic       clk,
  input  logic       load,
  input  cfg_t       cfg,
  input  mul_stage_t src,
  output logic [7:0] left_drive,
  output logic [7:0] right_drive,
  output logic       halted
);

  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] corr;
  logic signed [ACC_W:0]   base;
  logic signed [ACC_W:0]   corr_x;
  logic signed [ACC_W:0]   left_sum;
  logic signed [ACC_W:0]   right_sum;
  logic [7:0]              left_clamped;
  logic [7:0]              right_clamped;

  always_comb begin
    acc = {{(ACC_W-31){src.prod_p[30]}}, src.prod_p}
        + {{(ACC_W-32){src.prod_d[31]}}, src.prod_d}
        + {{(ACC_W-49){src.prod_i[48]}}, src.prod_i};
    // arithmetic shift floors toward minus infinity
    corr      = acc >>> GAIN_FRAC_BITS;
    base      = {{(ACC_W-7){1'b0}}, cfg.max_speed};
    corr_x    = {corr[ACC_W-1], corr};
    left_sum  = base + corr_x;
    right_sum = base - corr_x;

    if (left_sum[ACC_W]) begin
      left_clamped = '0;
    end else if (left_sum > base) begin
      left_clamped = cfg.max_speed;
    end else begin
      left_clamped = left_sum[7:0];
    end

    if (right_sum[ACC_W]) begin
      right_clamped = '0;
    end else if (right_sum > base) begin
      right_clamped = cfg.max_speed;
    end else begin
      right_clamped = right_sum[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      left_drive  <= src.halted ? 8'd0 : left_clamped;
      right_drive <= src.halted ? 8'd0 : right_clamped;
      halted      <= src.halted;
    end
  end

endmodule

// File: rtl/line_follower_pid_drive_core.sv
// ----------------------------------------------------------------------------
// line_follower_pid_drive_core
// PID differential drive for a line follower with finish-marker stop.
// ----------------------------------------------------------------------------
//  channel    dir  payload                                  handshake
//  ctl_in     in   line_position, marker_level, now_ms      valid / ready
//  drv_out    out  left_drive, right_drive, halted          valid / ready
//  cfg        in   cfg_index, cfg_data                      cfg_we only
//
//  One tick per cycle sustained while drv_out is ready; a result passes the
//  input register, error stage, multiply stage and output register in turn.
//  The loop that bounds the rate is the error / sum / marker update, which
//  closes within the error stage.
//  Synchronous reset clears the pipeline valid bits, PID and marker state,
//  and loads the register defaults. Stalls on drv_out fill bubbles first;
//  ctl_in.ready drops only once all four stages hold a tick.
// ----------------------------------------------------------------------------
module line_follower_pid_drive_core
  import lfpd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  lfpd_tick_if.sink   ctl_in,
  lfpd_drive_if.source drv_out
);

  cfg_t cfg;

  // Configuration registers; an unknown index is dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.line_target   <= RST_LINE_TARGET;
      cfg.max_speed     <= RST_MAX_SPEED;
      cfg.gain_p        <= RST_GAIN_P;
      cfg.gain_i        <= RST_GAIN_I;
      cfg.gain_d        <= RST_GAIN_D;
      cfg.finish_edges  <= RST_FINISH_EDGES;
      cfg.stop_delay_ms <= RST_STOP_DELAY_MS;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_LINE_TARGET:   cfg.line_target   <= cfg_data[12:0];
        REG_MAX_SPEED:     cfg.max_speed     <= cfg_data[7:0];
        REG_GAIN_P:        cfg.gain_p        <= cfg_data;
        REG_GAIN_I:        cfg.gain_i        <= cfg_data;
        REG_GAIN_D:        cfg.gain_d        <= cfg_data;
        REG_FINISH_EDGES:  cfg.finish_edges  <= cfg_data[3:0];
        REG_STOP_DELAY_MS: cfg.stop_delay_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pipeline occupancy: input register, error stage, multiply stage, output.
  logic in_valid;
  logic err_valid;
  logic mul_valid;
  logic out_valid;

  logic take_in;
  logic take_err;
  logic take_mul;
  logic take_out;
  logic out_xfer;

  // Each stage loads when its upstream holds a tick and it is empty or
  // emptying in the same cycle; this collapses bubbles during a stall.
  always_comb begin
    out_xfer = out_valid && drv_out.ready;
    take_out = mul_valid && (!out_valid || out_xfer);
    take_mul = err_valid && (!mul_valid || take_out);
    take_err = in_valid  && (!err_valid || take_mul);
    take_in  = ctl_in.valid && ctl_in.ready;
  end

  assign ctl_in.ready = !in_valid || take_err;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      err_valid <= 1'b0;
      mul_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (take_in || take_err) begin
        in_valid <= take_in;
      end
      if (take_err || take_mul) begin
        err_valid <= take_err;
      end
      if (take_mul || take_out) begin
        mul_valid <= take_mul;
      end
      if (take_out || out_xfer) begin
        out_valid <= take_out;
      end
    end
  end

  // Input register: hold the tick payload until the error stage takes it.
  logic [12:0] line_position;
  logic        marker_level;
  logic [31:0] now_ms;

  always_ff @(posedge clk) begin
    if (take_in) begin
      line_position <= ctl_in.line_position;
      marker_level  <= ctl_in.marker_level;
      now_ms        <= ctl_in.now_ms;
    end
  end

  err_stage_t err_stage;
  mul_stage_t mul_stage;

  lfpd_err_stage u_err (
    .clk           (clk),
    .rst           (rst),
    .load          (take_err),
    .cfg           (cfg),
    .line_position (line_position),
    .marker_level  (marker_level),
    .now_ms        (now_ms),
    .stage         (err_stage)
  );

  lfpd_mul_stage u_mul (
    .clk   (clk),
    .load  (take_mul),
    .cfg   (cfg),
    .src   (err_stage),
    .stage (mul_stage)
  );

  lfpd_drv_stage u_drv (
    .clk         (clk),
    .load        (take_out),
    .cfg         (cfg),
    .src         (mul_stage),
    .left_drive  (drv_out.left_drive),
    .right_drive (drv_out.right_drive),
    .halted      (drv_out.halted)
  );

  assign drv_out.valid = out_valid;

  `include "line_follower_pid_drive_core_macros.svh"

  // A halted result always carries zero drive.
  `LFPD_ASSERT_NOW(a_halt_zero, out_valid && drv_out.halted,
    drv_out.left_drive == 8'd0 && drv_out.right_drive == 8'd0,
    "halted result with nonzero drive")

  // Back-pressure reaches the input only with every stage occupied.
  `LFPD_ASSERT_NOW(a_full_on_stall, !ctl_in.ready,
    in_valid && err_valid && mul_valid && out_valid,
    "input stalled with a bubble in the pipeline")

  // A waiting result is never dropped.
  `LFPD_ASSERT_NEXT(a_hold_result, out_valid && !drv_out.ready, out_valid,
    "output result lost while stalled")

endmodule
